>>> rtl/tle_pkg.sv
// Types, constants and microcode ROM for the terminal line editor.
`timescale 1ns / 1ps
`default_nettype none
package tle_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 8;

  typedef enum logic [CFG_AW-1:0] {
    REG_LOGGED_IN = 3'd0,
    REG_ENTER     = 3'd1,
    REG_BACKSPACE = 3'd2,
    REG_ESCAPE    = 3'd3,
    REG_TAB       = 3'd4
  } reg_idx_t;

  localparam logic [7:0] RST_ENTER     = 8'd13;
  localparam logic [7:0] RST_BACKSPACE = 8'd8;
  localparam logic [7:0] RST_ESCAPE    = 8'd27;
  localparam logic [7:0] RST_TAB       = 8'd9;

  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_UP      = 8'h41;
  localparam logic [7:0] CH_DOWN    = 8'h42;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_CTL_TOP = 8'h20;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_MARK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TRIG_ENTER = 2'd0,
    TRIG_TAB   = 2'd1,
    TRIG_UP    = 2'd2,
    TRIG_DOWN  = 2'd3
  } trig_t;

  // microcode addresses
  typedef enum logic [3:0] {
    UA_FETCH    = 4'd0,
    UA_DISPATCH = 4'd1,
    UA_ENTER_NL = 4'd2,
    UA_LREAD    = 4'd3,
    UA_LEMIT    = 4'd4,
    UA_LDONE    = 4'd5,
    UA_MARK     = 4'd6,
    UA_BS1      = 4'd7,
    UA_BS2      = 4'd8,
    UA_BS3      = 4'd9,
    UA_PRINT    = 4'd10
  } upc_t;

  typedef enum logic [2:0] {
    EM_NONE  = 3'd0,
    EM_NL    = 3'd1,
    EM_MARK  = 3'd2,
    EM_BSP   = 3'd3,
    EM_SPC   = 3'd4,
    EM_PRINT = 3'd5,
    EM_LINE  = 3'd6
  } emit_t;

  typedef enum logic [1:0] {
    LS_ZERO     = 2'd0,
    LS_ONE      = 2'd1,
    LS_LEN_ZERO = 2'd2,
    LS_IDX_LAST = 2'd3
  } last_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_RD_FIRST = 3'd1,
    ACT_LINE_ADV = 3'd2,
    ACT_CLEAR    = 3'd3,
    ACT_BS_DEC   = 3'd4,
    ACT_STORE    = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    CD_NEVER    = 2'd0,
    CD_ALWAYS   = 2'd1,
    CD_LEN_ZERO = 2'd2,
    CD_IDX_MORE = 2'd3
  } cond_t;

  // jump to target when cond holds, else fall through to the next step
  typedef struct packed {
    logic  take_in;
    logic  dispatch;
    emit_t emit;
    last_t last_sel;
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '{1'b0, 1'b0, EM_NONE, LS_ZERO, ACT_NONE, CD_ALWAYS, UA_FETCH};
    case (pc)
      UA_FETCH:    w = '{1'b1, 1'b0, EM_NONE,  LS_ZERO,     ACT_NONE,     CD_ALWAYS,   UA_DISPATCH};
      UA_DISPATCH: w = '{1'b0, 1'b1, EM_NONE,  LS_ZERO,     ACT_NONE,     CD_NEVER,    UA_FETCH};
      UA_ENTER_NL: w = '{1'b0, 1'b0, EM_NL,    LS_LEN_ZERO, ACT_NONE,     CD_LEN_ZERO, UA_FETCH};
      UA_LREAD:    w = '{1'b0, 1'b0, EM_NONE,  LS_ZERO,     ACT_RD_FIRST, CD_NEVER,    UA_FETCH};
      UA_LEMIT:    w = '{1'b0, 1'b0, EM_LINE,  LS_IDX_LAST, ACT_LINE_ADV, CD_IDX_MORE, UA_LEMIT};
      UA_LDONE:    w = '{1'b0, 1'b0, EM_NONE,  LS_ZERO,     ACT_CLEAR,    CD_ALWAYS,   UA_FETCH};
      UA_MARK:     w = '{1'b0, 1'b0, EM_MARK,  LS_ONE,      ACT_NONE,     CD_ALWAYS,   UA_FETCH};
      UA_BS1:      w = '{1'b0, 1'b0, EM_BSP,   LS_ZERO,     ACT_BS_DEC,   CD_NEVER,    UA_FETCH};
      UA_BS2:      w = '{1'b0, 1'b0, EM_SPC,   LS_ZERO,     ACT_NONE,     CD_NEVER,    UA_FETCH};
      UA_BS3:      w = '{1'b0, 1'b0, EM_BSP,   LS_ONE,      ACT_NONE,     CD_ALWAYS,   UA_FETCH};
      UA_PRINT:    w = '{1'b0, 1'b0, EM_PRINT, LS_ONE,      ACT_STORE,    CD_ALWAYS,   UA_FETCH};
      default:     w = '{1'b0, 1'b0, EM_NONE,  LS_ZERO,     ACT_NONE,     CD_ALWAYS,   UA_FETCH};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/terminal_line_editor_unit.sv
// Terminal line editor: microcoded sequencer over a line store and output register.
// A new byte is taken only once the routine for the last byte has finished.
// One control word per cycle unless input or output back-pressure stalls it; one input
//   per program pass.
// Reset (rst_n low, synchronous) clears control state and register defaults, not the store.
`timescale 1ns / 1ps
`default_nettype none
module terminal_line_editor_unit #(
  parameter int LINE_DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] char_in
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [15:0]                     out_tdata,  // [7:0] data_byte, [9:8] trigger,
                                                      // [10] login_request, [11] overflow
  output logic [1:0]                      out_tuser,  // [1:0] kind
  output logic                            out_tlast,
  input  wire logic                       cfg_we,
  input  wire logic [tle_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [tle_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int LW = $clog2(LINE_DEPTH + 1);
  localparam int MEM_N = 2 ** AW;

  // configuration
  logic       logged_in_r;
  logic [7:0] enter_code_r, bs_code_r, esc_code_r, tab_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      logged_in_r  <= 1'b0;
      enter_code_r <= tle_pkg::RST_ENTER;
      bs_code_r    <= tle_pkg::RST_BACKSPACE;
      esc_code_r   <= tle_pkg::RST_ESCAPE;
      tab_code_r   <= tle_pkg::RST_TAB;
    end else if (cfg_we) begin
      case (tle_pkg::reg_idx_t'(cfg_addr))
        tle_pkg::REG_LOGGED_IN: logged_in_r  <= cfg_wdata[0];
        tle_pkg::REG_ENTER:     enter_code_r <= cfg_wdata;
        tle_pkg::REG_BACKSPACE: bs_code_r    <= cfg_wdata;
        tle_pkg::REG_ESCAPE:    esc_code_r   <= cfg_wdata;
        tle_pkg::REG_TAB:       tab_code_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer and datapath state
  tle_pkg::upc_t   pc_r, pc_nxt;
  tle_pkg::uword_t uw;
  tle_pkg::trig_t  trig_r, trig_nxt;
  logic [7:0]      char_r;
  logic [LW-1:0]   len_r, idx_r;
  logic [AW-1:0]   colon_pos_r;
  logic            colon_valid_r;
  logic            esc_r, esc_cnt_r;
  logic [7:0]      esc_first_r;

  logic [7:0]      mem [MEM_N];
  logic [7:0]      mem_q;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;

  logic            out_valid_r;
  logic [7:0]      out_data_r;
  tle_pkg::kind_t  out_kind_r;
  tle_pkg::trig_t  out_trig_r;
  logic            out_login_r, out_ovf_r, out_last_r;

  logic            in_fire, out_free, emit_go, proceed, cond_hit;
  logic            len_zero, full, idx_last, mask;
  logic [LW-1:0]   len_dec, idx_inc;
  tle_pkg::upc_t   disp_tgt;
  logic [7:0]      e_data;
  tle_pkg::kind_t  e_kind;
  tle_pkg::trig_t  e_trig;
  logic            e_login, e_ovf, e_last;

  assign uw       = tle_pkg::ucode(pc_r);
  assign in_tready = uw.take_in;
  assign in_fire  = in_tvalid & in_tready;
  assign out_free = ~out_valid_r | out_tready;
  assign emit_go  = (uw.emit != tle_pkg::EM_NONE);
  assign proceed  = (~uw.take_in | in_fire) & (~emit_go | out_free);

  assign len_zero = (len_r == '0);
  assign full     = (len_r == LW'(LINE_DEPTH));
  assign len_dec  = len_r - LW'(1);
  assign idx_inc  = idx_r + LW'(1);
  assign idx_last = (idx_r == len_dec);
  assign mask     = ~logged_in_r & colon_valid_r;

  // dispatch decode: pick the routine and the request cause for the fetched byte
  always_comb begin
    disp_tgt = tle_pkg::UA_FETCH;
    trig_nxt = trig_r;
    if (esc_r) begin
      if (esc_cnt_r && logged_in_r && esc_first_r == tle_pkg::CH_LBRACK &&
          (char_r == tle_pkg::CH_UP || char_r == tle_pkg::CH_DOWN)) begin
        trig_nxt = (char_r == tle_pkg::CH_UP) ? tle_pkg::TRIG_UP : tle_pkg::TRIG_DOWN;
        disp_tgt = len_zero ? tle_pkg::UA_MARK : tle_pkg::UA_LREAD;
      end
    end else if (char_r == enter_code_r) begin
      trig_nxt = tle_pkg::TRIG_ENTER;
      disp_tgt = tle_pkg::UA_ENTER_NL;
    end else if (char_r == esc_code_r) begin
      disp_tgt = tle_pkg::UA_FETCH;
    end else if (char_r == bs_code_r) begin
      disp_tgt = len_zero ? tle_pkg::UA_FETCH : tle_pkg::UA_BS1;
    end else if (char_r == tab_code_r) begin
      if (logged_in_r) begin
        trig_nxt = tle_pkg::TRIG_TAB;
        disp_tgt = len_zero ? tle_pkg::UA_MARK : tle_pkg::UA_LREAD;
      end
    end else if (char_r < tle_pkg::CH_CTL_TOP || char_r == tle_pkg::CH_DEL) begin
      disp_tgt = tle_pkg::UA_FETCH;
    end else begin
      disp_tgt = tle_pkg::UA_PRINT;
    end
  end

  always_comb begin
    case (uw.cond)
      tle_pkg::CD_NEVER:    cond_hit = 1'b0;
      tle_pkg::CD_ALWAYS:   cond_hit = 1'b1;
      tle_pkg::CD_LEN_ZERO: cond_hit = len_zero;
      tle_pkg::CD_IDX_MORE: cond_hit = ~idx_last;
      default:              cond_hit = 1'b1;
    endcase
    if (!proceed)
      pc_nxt = pc_r;
    else if (uw.dispatch)
      pc_nxt = disp_tgt;
    else if (cond_hit)
      pc_nxt = uw.target;
    else
      pc_nxt = tle_pkg::upc_t'(pc_r + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      pc_r <= tle_pkg::UA_FETCH;
    else
      pc_r <= pc_nxt;
  end

  // result selection
  always_comb begin
    e_data  = 8'd0;
    e_kind  = tle_pkg::KIND_ECHO;
    e_trig  = tle_pkg::TRIG_ENTER;
    e_login = 1'b0;
    e_ovf   = 1'b0;
    case (uw.emit)
      tle_pkg::EM_NL:   e_data = tle_pkg::CH_NL;
      tle_pkg::EM_MARK: begin
        e_kind = tle_pkg::KIND_MARK;
        e_trig = trig_r;
      end
      tle_pkg::EM_BSP:  e_data = tle_pkg::CH_BS;
      tle_pkg::EM_SPC:  e_data = tle_pkg::CH_SPACE;
      tle_pkg::EM_PRINT: begin
        e_ovf  = full;
        e_data = full ? 8'd0 : (mask ? tle_pkg::CH_STAR : char_r);
      end
      tle_pkg::EM_LINE: begin
        e_kind  = tle_pkg::KIND_LINE;
        e_data  = mem_q;
        e_trig  = trig_r;
        e_login = ~logged_in_r;
      end
      default: ;
    endcase
    case (uw.last_sel)
      tle_pkg::LS_ZERO:     e_last = 1'b0;
      tle_pkg::LS_ONE:      e_last = 1'b1;
      tle_pkg::LS_LEN_ZERO: e_last = len_zero;
      tle_pkg::LS_IDX_LAST: e_last = idx_last;
      default:              e_last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (emit_go && proceed)
      out_valid_r <= 1'b1;
    else if (out_tready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_go && proceed) begin
      out_data_r  <= e_data;
      out_kind_r  <= e_kind;
      out_trig_r  <= e_trig;
      out_login_r <= e_login;
      out_ovf_r   <= e_ovf;
      out_last_r  <= e_last;
    end
  end

  // line store, one write and one registered read port
  assign rd_en   = proceed & (uw.act == tle_pkg::ACT_RD_FIRST || uw.act == tle_pkg::ACT_LINE_ADV);
  assign rd_addr = (uw.act == tle_pkg::ACT_RD_FIRST) ? '0 : idx_inc[AW-1:0];

  always_ff @(posedge clk) begin
    if (proceed && uw.act == tle_pkg::ACT_STORE && !full)
      mem[len_r[AW-1:0]] <= char_r;
    if (rd_en)
      mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_fire)
      char_r <= in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r         <= '0;
      idx_r         <= '0;
      colon_pos_r   <= '0;
      colon_valid_r <= 1'b0;
      esc_r         <= 1'b0;
      esc_cnt_r     <= 1'b0;
      esc_first_r   <= 8'd0;
      trig_r        <= tle_pkg::TRIG_ENTER;
    end else if (proceed) begin
      if (uw.dispatch) begin
        trig_r <= trig_nxt;
        if (esc_r) begin
          if (!esc_cnt_r) begin
            esc_first_r <= char_r;
            esc_cnt_r   <= 1'b1;
          end else begin
            esc_r     <= 1'b0;
            esc_cnt_r <= 1'b0;
          end
        end else if (char_r != enter_code_r && char_r == esc_code_r) begin
          esc_r     <= 1'b1;
          esc_cnt_r <= 1'b0;
        end
      end
      case (uw.act)
        tle_pkg::ACT_RD_FIRST: idx_r <= '0;
        tle_pkg::ACT_LINE_ADV: idx_r <= idx_inc;
        tle_pkg::ACT_CLEAR: begin
          len_r         <= '0;
          colon_pos_r   <= '0;
          colon_valid_r <= 1'b0;
        end
        tle_pkg::ACT_BS_DEC: begin
          len_r <= len_dec;
          if (colon_valid_r && colon_pos_r == len_dec[AW-1:0])
            colon_valid_r <= 1'b0;
        end
        tle_pkg::ACT_STORE: begin
          if (!full) begin
            len_r <= len_r + LW'(1);
            if (char_r == tle_pkg::CH_COLON && !colon_valid_r) begin
              colon_valid_r <= 1'b1;
              colon_pos_r   <= len_r[AW-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_ovf_r, out_login_r, out_trig_r, out_data_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(LINE_DEPTH))
    else $error("line length beyond store depth");

  a_colon_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    colon_valid_r |-> (LW'(colon_pos_r) < len_r))
    else $error("colon position outside the line");

  a_fetch_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (pc_r == tle_pkg::UA_DISPATCH))
    else $error("accepted item not dispatched");

  a_drain_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == tle_pkg::UA_LEMIT) |-> (idx_r < len_r))
    else $error("line drain index past line length");

  a_mark_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == tle_pkg::KIND_MARK) |-> out_last_r)
    else $error("empty request marker not last");

endmodule
`default_nettype wire

>>> tb/sv/terminal_line_editor_checker.sv
// Checker for the terminal line editor: predicts each item's output and compares it.
`timescale 1ns / 1ps
module terminal_line_editor_checker #(
  parameter int LINE_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [7:0]                 in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [15:0]                out_tdata,
  input  logic [1:0]                 out_tuser,
  input  logic                       out_tlast,
  input  logic                       cfg_we,
  input  logic [tle_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tle_pkg::CFG_DW-1:0] cfg_wdata,
  output int                         mismatch_count,
  output int                         pending_count
);
  import tle_pkg::*;

  typedef struct {
    kind_t      kind;
    logic [7:0] data_byte;
    trig_t      trigger;
    logic       login_request;
    logic       overflow;
    logic       last;
  } term_out_t;

  term_out_t  term_out_q[$];
  term_out_t  held_out;
  logic       held_valid = 1'b0;
  int         err_count = 0;

  logic       mode_logged_in;
  logic [7:0] code_enter;
  logic [7:0] code_bs;
  logic [7:0] code_esc;
  logic [7:0] code_tab;

  logic [7:0] line_buf [LINE_DEPTH];
  logic [5:0] line_len;
  logic [4:0] colon_pos;
  logic       colon_seen;
  logic       esc_active;
  logic [1:0] esc_count;
  logic [7:0] esc_first;

  // the newest result is held back so the final one of an item can get its last flag
  task add_out(input kind_t k, input logic [7:0] d, input trig_t t,
               input logic lr, input logic ov);
    if (held_valid) term_out_q.push_back(held_out);
    held_out.kind          = k;
    held_out.data_byte     = d;
    held_out.trigger       = t;
    held_out.login_request = lr;
    held_out.overflow      = ov;
    held_out.last          = 1'b0;
    held_valid             = 1'b1;
  endtask

  task flush_line(input trig_t t);
    int i;
    if (line_len == '0) begin
      // enter on an empty line gives only the newline; tab and arrows give a marker
      if (t != TRIG_ENTER) add_out(KIND_MARK, 8'h00, t, 1'b0, 1'b0);
    end else begin
      for (i = 0; i < line_len; i++)
        add_out(KIND_LINE, line_buf[i], t, ~mode_logged_in, 1'b0);
      line_len   = '0;
      colon_seen = 1'b0;
      colon_pos  = '0;
    end
  endtask

  task take_char(input logic [7:0] c);
    if (line_len >= LINE_DEPTH) begin
      add_out(KIND_ECHO, 8'h00, TRIG_ENTER, 1'b0, 1'b1);
    end else begin
      line_buf[line_len] = c;
      if (c == CH_COLON && !colon_seen) begin
        colon_seen = 1'b1;
        colon_pos  = line_len[4:0];
      end
      line_len = line_len + 6'd1;
      if (!mode_logged_in && colon_seen && line_len > {1'b0, colon_pos} + 6'd1)
        add_out(KIND_ECHO, CH_STAR, TRIG_ENTER, 1'b0, 1'b0);
      else
        add_out(KIND_ECHO, c, TRIG_ENTER, 1'b0, 1'b0);
    end
  endtask

  task edit_line_char(input logic [7:0] c);
    if (esc_active) begin
      // the two bytes after escape are captured whatever they are
      if (esc_count == 2'd0) begin
        esc_first = c;
        esc_count = 2'd1;
      end else begin
        esc_active = 1'b0;
        esc_count  = 2'd0;
        if (mode_logged_in && esc_first == CH_LBRACK) begin
          if (c == CH_UP) flush_line(TRIG_UP);
          else if (c == CH_DOWN) flush_line(TRIG_DOWN);
        end
      end
    end else if (c == code_enter) begin
      add_out(KIND_ECHO, CH_NL, TRIG_ENTER, 1'b0, 1'b0);
      flush_line(TRIG_ENTER);
    end else if (c == code_esc) begin
      esc_active = 1'b1;
      esc_count  = 2'd0;
    end else if (c == code_bs) begin
      if (line_len != '0) begin
        line_len = line_len - 6'd1;
        if (colon_seen && {1'b0, colon_pos} == line_len) colon_seen = 1'b0;
        add_out(KIND_ECHO, CH_BS, TRIG_ENTER, 1'b0, 1'b0);
        add_out(KIND_ECHO, CH_SPACE, TRIG_ENTER, 1'b0, 1'b0);
        add_out(KIND_ECHO, CH_BS, TRIG_ENTER, 1'b0, 1'b0);
      end
    end else if (c == code_tab) begin
      if (mode_logged_in) flush_line(TRIG_TAB);
    end else if (c >= CH_CTL_TOP && c != CH_DEL) begin
      // other control bytes fall through and are dropped
      take_char(c);
    end
    if (held_valid) begin
      held_out.last = 1'b1;
      term_out_q.push_back(held_out);
      held_valid = 1'b0;
    end
  endtask

  task check_out();
    term_out_t want;
    if (term_out_q.size() == 0) begin
      $error("unexpected result: kind %0d data_byte 0x%02h", out_tuser, out_tdata[7:0]);
      err_count++;
    end else begin
      want = term_out_q.pop_front();
      if (out_tuser !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, out_tuser);
        err_count++;
      end
      if (out_tdata[7:0] !== want.data_byte) begin
        $error("data_byte: expected 0x%02h, actual 0x%02h", want.data_byte, out_tdata[7:0]);
        err_count++;
      end
      if (out_tdata[9:8] !== want.trigger) begin
        $error("trigger: expected %0d, actual %0d", want.trigger, out_tdata[9:8]);
        err_count++;
      end
      if (out_tdata[10] !== want.login_request) begin
        $error("login_request: expected %0d, actual %0d", want.login_request, out_tdata[10]);
        err_count++;
      end
      if (out_tdata[11] !== want.overflow) begin
        $error("overflow: expected %0d, actual %0d", want.overflow, out_tdata[11]);
        err_count++;
      end
      if (out_tlast !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, out_tlast);
        err_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_logged_in = 1'b0;
      code_enter     = RST_ENTER;
      code_bs        = RST_BACKSPACE;
      code_esc       = RST_ESCAPE;
      code_tab       = RST_TAB;
      line_len       = '0;
      colon_pos      = '0;
      colon_seen     = 1'b0;
      esc_active     = 1'b0;
      esc_count      = 2'd0;
      esc_first      = 8'h00;
      held_valid     = 1'b0;
      term_out_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_LOGGED_IN: mode_logged_in = cfg_wdata[0];
          REG_ENTER:     code_enter     = cfg_wdata;
          REG_BACKSPACE: code_bs        = cfg_wdata;
          REG_ESCAPE:    code_esc       = cfg_wdata;
          REG_TAB:       code_tab       = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) edit_line_char(in_tdata);
      if (out_tvalid && out_tready) check_out();
    end
    mismatch_count <= err_count;
    pending_count  <= term_out_q.size();
  end

endmodule

>>> tb/sv/terminal_line_editor_unit_tb.sv
// Testbench top for the terminal line editor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module terminal_line_editor_unit_tb;
  import tle_pkg::*;

  localparam int LINE_DEPTH   = 32;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 420;
  localparam int CALM_TAIL    = 60;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = 8'h00;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;   // [7:0] data_byte, [9:8] trigger, [10] login_request,
                                  // [11] overflow
  logic [1:0]        out_tuser;   // [1:0] kind
  logic              out_tlast;
  logic              cfg_we     = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;

  int                mismatch_count;
  int                pending_count;
  int                cycle_count = 0;
  int                stall_left  = 0;
  int                line_items  = 0;
  bit                idle_on     = 1'b1;

  // codes currently programmed, used to build well-formed sequences
  logic [7:0]        cur_enter = RST_ENTER;
  logic [7:0]        cur_bs    = RST_BACKSPACE;
  logic [7:0]        cur_esc   = RST_ESCAPE;
  logic [7:0]        cur_tab   = RST_TAB;

  always #5 clk = ~clk;

  terminal_line_editor_unit #(.LINE_DEPTH(LINE_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  terminal_line_editor_checker #(.LINE_DEPTH(LINE_DEPTH)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("terminal_line_editor_unit_tb: FAIL");
      $finish;
    end
  end

  // receiver stalls in bursts of random length, only while idle_on is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // every accepted item counts toward the run length
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    line_items++;
  endtask

  // sender holds off until every predicted result has come, then lets the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic li, input logic [7:0] ent, input logic [7:0] bs,
                            input logic [7:0] esc, input logic [7:0] tab);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_LOGGED_IN;
    cfg_wdata <= {7'd0, li};
    @(posedge clk);
    cfg_addr  <= REG_ENTER;
    cfg_wdata <= ent;
    @(posedge clk);
    cfg_addr  <= REG_BACKSPACE;
    cfg_wdata <= bs;
    @(posedge clk);
    cfg_addr  <= REG_ESCAPE;
    cfg_wdata <= esc;
    @(posedge clk);
    cfg_addr  <= REG_TAB;
    cfg_wdata <= tab;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_enter = ent;
    cur_bs    = bs;
    cur_esc   = esc;
    cur_tab   = tab;
  endtask

  function automatic logic [7:0] pick_print();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CH_COLON;
    if (r == 1) return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  task automatic send_line();
    int n;
    int k;
    int sel;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0)
        send_byte(cur_bs);
      send_byte(pick_print());
    end
    sel = $urandom_range(0, 5);
    if (sel <= 2) begin
      send_byte(cur_enter);
    end else if (sel == 3) begin
      send_byte(cur_tab);
    end else begin
      send_byte(cur_esc);
      send_byte(CH_LBRACK);
      send_byte((sel == 4) ? CH_UP : CH_DOWN);
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_byte(8'($urandom));
      1: send_byte(8'($urandom_range(0, 31)));
      2: begin
        send_byte(cur_esc);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
      end
      3: begin
        // left/right arrows
        send_byte(cur_esc);
        send_byte(CH_LBRACK);
        send_byte(8'($urandom_range(8'h43, 8'h44)));
      end
      default: begin
        // enter and backspace swallowed by an escape capture
        send_byte(cur_esc);
        send_byte(cur_enter);
        send_byte(cur_bs);
      end
    endcase
  endtask

  initial begin
    int phase;
    int phase_end;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // login mode with reset codes: masking after colon, colon removal, drops
    send_byte("a");   send_byte(CH_COLON); send_byte("x");
    send_byte(CH_BS); send_byte(CH_BS);    send_byte(8'hFF);
    send_byte(CH_DEL); send_byte(8'h00);   send_byte(RST_TAB);
    send_byte(RST_ESCAPE); send_byte(CH_LBRACK); send_byte(CH_UP);
    send_byte(RST_ENTER);  send_byte(RST_ENTER); send_byte(CH_BS);

    // logged-in: empty tab and arrow markers, left arrow dropped, tab and up end lines
    set_config(1'b1, RST_ENTER, RST_BACKSPACE, RST_ESCAPE, RST_TAB);
    send_byte(RST_TAB);
    send_byte(RST_ESCAPE); send_byte(CH_LBRACK); send_byte(CH_DOWN);
    send_byte("b");
    send_byte(RST_ESCAPE); send_byte(CH_LBRACK); send_byte(8'h44);
    send_byte(RST_TAB);
    send_byte("c");
    send_byte(RST_ESCAPE); send_byte(CH_LBRACK); send_byte(CH_UP);

    phase = 0;
    while (line_items < RANDOM_ITEMS) begin
      case (phase)
        0: set_config(1'b1, 8'hFF, 8'h00, 8'h7F, 8'h20);
        1: set_config(1'b0, 8'h00, 8'hFF, 8'h01, CH_COLON);
        default: begin
          if ($urandom_range(0, 1) == 0)
            set_config(1'($urandom_range(0, 1)), RST_ENTER, RST_BACKSPACE, RST_ESCAPE,
                       RST_TAB);
          else
            set_config(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
        end
      endcase
      idle_on   = (phase % 3 != 2);
      phase_end = line_items + 50;
      while (line_items < phase_end && line_items < RANDOM_ITEMS) begin
        if (RANDOM_ITEMS - line_items <= CALM_TAIL) idle_on = 1'b0;
        if ($urandom_range(0, 9) < 7) send_line();
        else send_noise();
      end
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("terminal_line_editor_unit_tb: PASS");
    end else begin
      $display("terminal_line_editor_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
